// File: rtl/core/ffha_pkg.sv
package ffha_pkg;

    localparam int HEAP_BYTES    = 32768;
    localparam int MAX_BLOCKS    = 256;
    localparam int POINTER_BYTES = 8;

    localparam int LINK_W = $clog2(HEAP_BYTES);
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int CALC_W = LINK_W + 3;
    localparam int ADDR_W = 15;
    localparam int SIZE_W = 16;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic              free;
        logic [LINK_W-1:0] link;
    } entry_t;

    typedef struct packed {
        logic              fit;
        logic              split;
        logic [LINK_W-1:0] new_link;
    } fit_t;

endpackage

// File: rtl/core/ffha_fit.sv
module ffha_fit (
    input  logic [ffha_pkg::LINK_W-1:0] cur_link,
    input  logic                        cur_free,
    input  logic [ffha_pkg::LINK_W-1:0] next_link,
    input  logic                        has_next,
    input  logic                        room,
    input  logic [ffha_pkg::SIZE_W-1:0] req,
    output ffha_pkg::fit_t              result
);
    import ffha_pkg::*;

    logic [CALC_W-1:0] link_w;
    logic [CALC_W-1:0] next_w;
    logic [CALC_W-1:0] req_w;
    logic [CALC_W-1:0] used_last;
    logic [CALC_W-1:0] used_inner;
    logic [CALC_W-1:0] size;
    logic [CALC_W-1:0] need;
    logic [CALC_W-1:0] split_link;

    always_comb
    begin
        link_w     = CALC_W'(cur_link);
        next_w     = CALC_W'(next_link);
        req_w      = CALC_W'(req);
        used_last  = link_w + CALC_W'(POINTER_BYTES);
        used_inner = link_w + CALC_W'(POINTER_BYTES + 1);
        need       = req_w + CALC_W'(POINTER_BYTES + 1);
        split_link = link_w + need;
        if (has_next)
        begin
            size = (next_w >= used_inner) ? (next_w - used_inner) : '0;
        end
        else
        begin
            size = (CALC_W'(HEAP_BYTES) >= used_last) ? (CALC_W'(HEAP_BYTES) - used_last) : '0;
        end
        result.fit      = cur_free && (req_w != '0) && (size >= req_w);
        result.split    = (size > need) && room && (split_link < CALC_W'(HEAP_BYTES));
        result.new_link = split_link[LINK_W-1:0];
    end

endmodule

// File: rtl/core/first_fit_heap_allocator.sv
// First-fit heap allocator with coalescing. Each item is an allocate (tuser 0) or a
// free (tuser 1) and yields exactly one result item. The block table lives in one
// synchronous RAM of MAX_BLOCKS entries and is walked one entry per cycle from the
// start up to and including the chosen block (the whole table on a failed search). A
// split or a merge then moves every later entry, up by one on a split and down by one
// or two on a merge, with one RAM read and write a cycle, and a split then writes the
// new free entry. An allocate of size 0 goes straight to its result without reading the
// table. A result that waits on m_tready sits in the output register while the block
// takes the next item, which stalls before its own result until the register is free.
// After reset the block writes the first table entry before it accepts items.
module first_fit_heap_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [15:0] request_size, [30:16] free_address
    input  logic        s_tuser,  // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // [14:0] data_address
    output logic        m_tuser   // ok
);
    import ffha_pkg::*;

    typedef enum logic [6:0] {
        ST_INIT   = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_LOAD   = 7'b0000100,
        ST_SCAN   = 7'b0001000,
        ST_MOVE   = 7'b0010000,
        ST_INSERT = 7'b0100000,
        ST_RESULT = 7'b1000000
    } state_t;

    entry_t            mem [MAX_BLOCKS];
    entry_t            rd_data_reg;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    entry_t            cur_reg, cur_next;
    logic              prev_free_reg, prev_free_next;
    logic              func_reg, func_next;
    logic [SIZE_W-1:0] req_reg, req_next;
    logic [ADDR_W-1:0] faddr_reg, faddr_next;
    logic [IDX_W-1:0]  mv_src_reg, mv_src_next;
    logic [IDX_W-1:0]  mv_end_reg, mv_end_next;
    logic              mv_up_reg, mv_up_next;
    logic              mv_gap_reg, mv_gap_next;
    logic [LINK_W-1:0] ins_link_reg, ins_link_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic              res_ok_reg, res_ok_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic              out_ok_reg, out_ok_next;

    fit_t              fit;
    logic [CNT_W:0]    idx_ext;
    logic              has_next;
    logic              has_next2;
    logic              match;
    logic              next_free;
    logic              prev_free;
    logic [CNT_W:0]    mv_start;
    logic [CNT_W-1:0]  count_m1;
    logic [CALC_W-1:0] data_sum;

    ffha_fit u_fit (
        .cur_link  (cur_reg.link),
        .cur_free  (cur_reg.free),
        .next_link (rd_data_reg.link),
        .has_next  (has_next),
        .room      (count_reg < CNT_W'(MAX_BLOCKS)),
        .req       (req_reg),
        .result    (fit)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        idx_ext   = (CNT_W + 1)'(idx_reg);
        has_next  = (idx_ext + (CNT_W + 1)'(1)) < (CNT_W + 1)'(count_reg);
        has_next2 = (idx_ext + (CNT_W + 1)'(2)) < (CNT_W + 1)'(count_reg);
        data_sum  = CALC_W'(cur_reg.link) + CALC_W'(POINTER_BYTES);
        match     = (data_sum == CALC_W'(faddr_reg));
        next_free = has_next && rd_data_reg.free;
        prev_free = (idx_reg != '0) && prev_free_reg;
        mv_start  = (next_free ? (idx_ext + (CNT_W + 1)'(2)) : (idx_ext + (CNT_W + 1)'(1)));
        count_m1  = count_reg - CNT_W'(1);
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        prev_free_next = prev_free_reg;
        func_next      = func_reg;
        req_next       = req_reg;
        faddr_next     = faddr_reg;
        mv_src_next    = mv_src_reg;
        mv_end_next    = mv_end_reg;
        mv_up_next     = mv_up_reg;
        mv_gap_next    = mv_gap_reg;
        ins_link_next  = ins_link_reg;
        res_addr_next  = res_addr_reg;
        res_ok_next    = res_ok_reg;
        out_valid_next = out_valid_reg;
        out_addr_next  = out_addr_reg;
        out_ok_next    = out_ok_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        s_tready       = (state_reg == ST_IDLE);

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                wr_en        = 1'b1;
                wr_addr      = '0;
                wr_data.free = 1'b1;
                wr_data.link = LINK_W'(1);
                state_next   = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next  = s_tuser;
                    req_next   = s_tdata[15:0];
                    faddr_next = s_tdata[30:16];
                    if ((s_tuser == FUNC_ALLOC) && (s_tdata[15:0] == '0))
                    begin
                        res_ok_next   = 1'b0;
                        res_addr_next = '0;
                        state_next    = ST_RESULT;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                cur_next       = rd_data_reg;
                idx_next       = '0;
                prev_free_next = 1'b0;
                if (count_reg > CNT_W'(1))
                begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(1);
                end
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                priority if ((func_reg == FUNC_ALLOC) && fit.fit)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = idx_reg;
                    wr_data.free  = 1'b0;
                    wr_data.link  = cur_reg.link;
                    res_ok_next   = 1'b1;
                    res_addr_next = data_sum[ADDR_W-1:0];
                    if (fit.split)
                    begin
                        count_next    = count_reg + CNT_W'(1);
                        ins_link_next = fit.new_link;
                        if (has_next)
                        begin
                            rd_en       = 1'b1;
                            rd_addr     = count_m1[IDX_W-1:0];
                            mv_src_next = count_m1[IDX_W-1:0];
                            mv_end_next = idx_reg + IDX_W'(1);
                            mv_up_next  = 1'b1;
                            state_next  = ST_MOVE;
                        end
                        else
                        begin
                            state_next = ST_INSERT;
                        end
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
                else if ((func_reg == FUNC_FREE) && match)
                begin
                    res_ok_next   = 1'b1;
                    res_addr_next = '0;
                    if (!prev_free)
                    begin
                        wr_en        = 1'b1;
                        wr_addr      = idx_reg;
                        wr_data.free = 1'b1;
                        wr_data.link = cur_reg.link;
                    end
                    if (next_free && prev_free)
                    begin
                        count_next = count_reg - CNT_W'(2);
                    end
                    else if (next_free || prev_free)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    if ((next_free || prev_free) && (mv_start < (CNT_W + 1)'(count_reg)))
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = mv_start[IDX_W-1:0];
                        mv_src_next = mv_start[IDX_W-1:0];
                        mv_end_next = count_m1[IDX_W-1:0];
                        mv_up_next  = 1'b0;
                        mv_gap_next = next_free && prev_free;
                        state_next  = ST_MOVE;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
                else if (has_next)
                begin
                    cur_next       = rd_data_reg;
                    prev_free_next = cur_reg.free;
                    idx_next       = idx_reg + IDX_W'(1);
                    if (has_next2)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = idx_reg + IDX_W'(2);
                    end
                end
                else
                begin
                    res_ok_next   = 1'b0;
                    res_addr_next = '0;
                    state_next    = ST_RESULT;
                end
            end
            ST_MOVE:
            begin
                wr_en   = 1'b1;
                wr_data = rd_data_reg;
                if (mv_up_reg)
                begin
                    wr_addr = mv_src_reg + IDX_W'(1);
                end
                else
                begin
                    wr_addr = mv_src_reg - (mv_gap_reg ? IDX_W'(2) : IDX_W'(1));
                end
                if (mv_src_reg == mv_end_reg)
                begin
                    state_next = mv_up_reg ? ST_INSERT : ST_RESULT;
                end
                else
                begin
                    rd_en       = 1'b1;
                    rd_addr     = mv_up_reg ? (mv_src_reg - IDX_W'(1)) : (mv_src_reg + IDX_W'(1));
                    mv_src_next = rd_addr;
                end
            end
            ST_INSERT:
            begin
                wr_en        = 1'b1;
                wr_addr      = idx_reg + IDX_W'(1);
                wr_data.free = 1'b1;
                wr_data.link = ins_link_reg;
                state_next   = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = res_addr_reg;
                    out_ok_next    = res_ok_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            count_reg     <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        cur_reg       <= cur_next;
        prev_free_reg <= prev_free_next;
        func_reg      <= func_next;
        req_reg       <= req_next;
        faddr_reg     <= faddr_next;
        mv_src_reg    <= mv_src_next;
        mv_end_reg    <= mv_end_next;
        mv_up_reg     <= mv_up_next;
        mv_gap_reg    <= mv_gap_next;
        ins_link_reg  <= ins_link_next;
        res_addr_reg  <= res_addr_next;
        res_ok_reg    <= res_ok_next;
        out_addr_reg  <= out_addr_next;
        out_ok_reg    <= out_ok_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16 - ADDR_W){1'b0}}, out_addr_reg};
    assign m_tuser  = out_ok_reg;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= CNT_W'(MAX_BLOCKS)))
        else $error("block count out of range");

    a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write hit the same table entry");

    a_insert_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INSERT) |-> ((idx_ext + (CNT_W + 1)'(1)) < (CNT_W + 1)'(count_reg)))
        else $error("insert beyond table end");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ok_reg) |-> (out_addr_reg == '0))
        else $error("failed item carries an address");
`endif

endmodule

// File: verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ffha_pkg::*;

    typedef enum {FILL, CHURN, DRAIN} mix_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [15:0] request_size, [30:16] free_address
    logic        s_tuser = 1'b0; // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [14:0] data_address
    logic        m_tuser;        // ok

    bit          calm = 1'b0;
    int unsigned random_sent = 0;

    first_fit_heap_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    class heap_scoreboard;
        typedef struct {
            logic [ADDR_W-1:0] addr;
            logic              ok;
        } result_t;

        logic [LINK_W-1:0] link_tab [MAX_BLOCKS];
        bit                free_tab [MAX_BLOCKS];
        int unsigned       n_blocks;
        result_t           expected_results [$];
        int                errors;

        function new();
            foreach (link_tab[i])
            begin
                link_tab[i] = '0;
                free_tab[i] = 1'b0;
            end
            link_tab[0] = 1;
            free_tab[0] = 1'b1;
            n_blocks = 1;
            errors = 0;
        endfunction

        function int unsigned data_size(int unsigned i);
            int unsigned link;
            int unsigned used;
            link = link_tab[i];
            if (i + 1 < n_blocks)
            begin
                used = link + POINTER_BYTES + 1;
                return (link_tab[i + 1] >= used) ? link_tab[i + 1] - used : 0;
            end
            return (HEAP_BYTES >= link + POINTER_BYTES) ? HEAP_BYTES - link - POINTER_BYTES : 0;
        endfunction

        function void remove_entry(int unsigned i);
            for (int unsigned k = i; k + 1 < n_blocks; k++)
            begin
                link_tab[k] = link_tab[k + 1];
                free_tab[k] = free_tab[k + 1];
            end
            n_blocks--;
        endfunction

        function void insert_free(int unsigned i, int unsigned link);
            if (n_blocks >= MAX_BLOCKS)
                return;
            for (int unsigned k = n_blocks; k > i; k--)
            begin
                link_tab[k] = link_tab[k - 1];
                free_tab[k] = free_tab[k - 1];
            end
            link_tab[i] = LINK_W'(link);
            free_tab[i] = 1'b1;
            n_blocks++;
        endfunction

        function bit predict_alloc(int unsigned req, output logic [ADDR_W-1:0] addr);
            int unsigned sz;
            int unsigned nl;
            addr = '0;
            if (req == 0)
                return 1'b0;
            for (int unsigned i = 0; i < n_blocks; i++)
            begin
                if (!free_tab[i])
                    continue;
                sz = data_size(i);
                if (sz < req)
                    continue;
                if (sz > req + 1 + POINTER_BYTES && n_blocks < MAX_BLOCKS)
                begin
                    nl = link_tab[i] + req + 1 + POINTER_BYTES;
                    if (nl < HEAP_BYTES)
                        insert_free(i + 1, nl);
                end
                free_tab[i] = 1'b0;
                addr = ADDR_W'(link_tab[i] + POINTER_BYTES);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit predict_free(int unsigned faddr);
            for (int unsigned i = 0; i < n_blocks; i++)
            begin
                if (link_tab[i] + POINTER_BYTES != faddr)
                    continue;
                free_tab[i] = 1'b1;
                if (i + 1 < n_blocks && free_tab[i + 1])
                    remove_entry(i + 1);
                if (i > 0 && free_tab[i - 1])
                    remove_entry(i);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_item(logic fn, logic [SIZE_W-1:0] req, logic [ADDR_W-1:0] faddr);
            result_t           r;
            logic [ADDR_W-1:0] a;
            if (fn == FUNC_ALLOC)
            begin
                r.ok = predict_alloc(req, a);
                r.addr = a;
            end
            else
            begin
                r.ok = predict_free(faddr);
                r.addr = '0;
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [ADDR_W-1:0] addr, logic ok);
            result_t r;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: result item with none expected: data_address %0d ok %0b",
                         $time, addr, ok);
                return;
            end
            r = expected_results.pop_front();
            if (addr !== r.addr)
            begin
                errors++;
                $display("%0t: data_address expected %0d actual %0d", $time, r.addr, addr);
            end
            if (ok !== r.ok)
            begin
                errors++;
                $display("%0t: ok expected %0b actual %0b", $time, r.ok, ok);
            end
        endfunction

        function bit pick_block(bit want_free, output logic [ADDR_W-1:0] addr);
            int unsigned hits [$];
            for (int unsigned i = 0; i < n_blocks; i++)
                if (free_tab[i] == want_free)
                    hits.push_back(i);
            addr = ADDR_W'($urandom);
            if (hits.size() == 0)
                return 1'b0;
            addr = ADDR_W'(link_tab[hits[$urandom_range(hits.size() - 1)]] + POINTER_BYTES);
            return 1'b1;
        endfunction
    endclass

    heap_scoreboard sb = new();

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        m_tready <= calm || ($urandom_range(0, 99) >= 12);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[ADDR_W-1:0], m_tuser);

    initial
    begin
        #50_000_000;
        $display("first_fit_heap_allocator test failed");
        $finish;
    end

    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return SIZE_W'($urandom_range(1, 32));
        if (r < 85)
            return SIZE_W'($urandom_range(33, 512));
        if (r < 97)
            return SIZE_W'($urandom_range(513, 4096));
        return SIZE_W'($urandom_range(0, HEAP_BYTES));
    endfunction

    task automatic send_item(logic fn, logic [SIZE_W-1:0] req, logic [ADDR_W-1:0] faddr);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 12) ? $urandom_range(1, 6) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= {1'b0, faddr, req};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(fn, req, faddr);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random(mix_t mix);
        int unsigned       r;
        logic [ADDR_W-1:0] fa;
        logic [SIZE_W-1:0] spare_size;
        calm = (random_sent >= 500 && random_sent < 720);
        random_sent++;
        r = $urandom_range(0, 99);
        spare_size = SIZE_W'($urandom_range(0, HEAP_BYTES));
        fa = ADDR_W'($urandom);
        case (mix)
            FILL:
                if (r < 85)
                    send_item(FUNC_ALLOC, pick_size(), fa);
                else
                begin
                    void'(sb.pick_block(1'b0, fa));
                    send_item(FUNC_FREE, spare_size, fa);
                end
            CHURN:
                if (r < 45)
                    send_item(FUNC_ALLOC, pick_size(), fa);
                else if (r < 85)
                begin
                    void'(sb.pick_block(1'b0, fa));
                    send_item(FUNC_FREE, spare_size, fa);
                end
                else if (r < 90)
                begin
                    void'(sb.pick_block(1'b1, fa));
                    send_item(FUNC_FREE, spare_size, fa);
                end
                else if (r < 94)
                    send_item(FUNC_FREE, spare_size, fa);
                else if (r < 97)
                    send_item(FUNC_ALLOC, '0, fa);
                else
                    send_item(FUNC_ALLOC, SIZE_W'($urandom_range(0, HEAP_BYTES)), fa);
            default:
                if (r < 92)
                begin
                    void'(sb.pick_block(1'b0, fa));
                    send_item(FUNC_FREE, spare_size, fa);
                end
                else if (r < 96)
                begin
                    void'(sb.pick_block(1'b1, fa));
                    send_item(FUNC_FREE, spare_size, fa);
                end
                else
                    send_item(FUNC_FREE, spare_size, fa);
        endcase
    endtask

    initial
    begin
        int   episode;
        int   len;
        mix_t mix;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_item(FUNC_FREE, '0, 15'd9);
        send_item(FUNC_FREE, '0, 15'd0);
        send_item(FUNC_ALLOC, 16'd0, '0);
        send_item(FUNC_ALLOC, 16'd32768, '0);
        send_item(FUNC_ALLOC, 16'd32759, '0);
        send_item(FUNC_ALLOC, 16'd1, '0);
        send_item(FUNC_FREE, '0, 15'd9);
        send_item(FUNC_ALLOC, 16'd32749, '0);
        send_item(FUNC_ALLOC, 16'd1, '0);
        send_item(FUNC_ALLOC, 16'd1, '0);
        send_item(FUNC_FREE, '0, 15'd32767);
        send_item(FUNC_FREE, '0, 15'd9);
        send_item(FUNC_FREE, '0, 15'd9);
        send_item(FUNC_ALLOC, 16'd1, '0);
        send_item(FUNC_ALLOC, 16'd2, '0);
        send_item(FUNC_ALLOC, 16'd3, '0);
        send_item(FUNC_FREE, '0, 15'd19);
        send_item(FUNC_FREE, '0, 15'd9);
        send_item(FUNC_ALLOC, 16'd12, '0);
        send_item(FUNC_ALLOC, 16'd21845, '0);
        send_item(FUNC_ALLOC, 16'd10922, '0);
        send_item(FUNC_FREE, '0, 15'd12345);
        send_item(FUNC_FREE, '0, 15'd32767);
        wait_drained();

        episode = 0;
        while (random_sent < 1400)
        begin
            if (episode == 0)
            begin
                mix = FILL;
                len = 300;
            end
            else
            begin
                mix = mix_t'($urandom_range(0, 2));
                len = (mix == DRAIN) ? sb.n_blocks + 4 : $urandom_range(30, 250);
            end
            repeat (len) send_random(mix);
            if ($urandom_range(0, 3) == 0)
                wait_drained();
            episode++;
        end

        wait_drained();
        repeat (2 * MAX_BLOCKS + 16) @(posedge clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("first_fit_heap_allocator test passed");
        else
            $display("first_fit_heap_allocator test failed");
        $finish;
    end

endmodule
